/* design/assert_macros.svh */
// Assertion helpers for the design files; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/qte_pkg.sv */
package qte_pkg;

    // Q30 component width, product width, term width
    localparam int Q_W = 31;
    localparam int P_W = 62;
    localparam int T_W = 34;
    // CORDIC vector width and angle width
    localparam int C_W = 36;
    localparam int A_W = 34;
    // Square root: operand width and result bits
    localparam int S_W = 62;
    localparam int SQ_STEPS = 31;
    localparam int ATAN_LEN = 24;

    localparam logic signed [T_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [A_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [A_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [30:0] RAD2DEG_Q24 = 31'sd961263669;

    // atan(2^-i) in Q30, truncated
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Sine and cosine terms in Q30
    typedef struct packed {
        logic signed [T_W-1:0] sinr;
        logic signed [T_W-1:0] cosr;
        logic signed [T_W-1:0] siny;
        logic signed [T_W-1:0] cosy;
        logic signed [T_W-1:0] sinp;
    } t_terms;

endpackage

/* design/qte_front.sv */
module qte_front import qte_pkg::*; #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic signed [COMPONENT_WIDTH-1:0] i_w,
    input  logic signed [COMPONENT_WIDTH-1:0] i_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_z,
    output logic                              o_valid,
    output t_terms                            o_terms
);

    logic signed [COMPONENT_WIDTH-1:0] w_in [4];
    logic signed [Q_W-1:0] w_q [4];
    logic signed [Q_W-1:0] r_q [4];
    logic signed [P_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic signed [P_W:0]   w_sr, w_cr, w_sy, w_cy, w_sp;
    logic r_v1, r_v2, r_v3;

    assign w_in[0] = i_w;
    assign w_in[1] = i_x;
    assign w_in[2] = i_y;
    assign w_in[3] = i_z;

    // Bring each component to Q30
    for (genvar c = 0; c < 4; c++) begin : g_conv
        logic signed [63:0] ext;
        assign ext = 64'(w_in[c]);
        if (COMPONENT_WIDTH <= Q_W) begin : g_up
            assign w_q[c] = Q_W'(ext <<< (Q_W - COMPONENT_WIDTH));
        end else begin : g_dn
            assign w_q[c] = Q_W'(ext >>> (COMPONENT_WIDTH - Q_W));
        end
    end

    // Stage 1: hold converted components
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < 4; c++) r_q[c] <= w_q[c];
        end
    end

    // Stage 2: pair products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wx <= r_q[0] * r_q[1];
            r_yz <= r_q[2] * r_q[3];
            r_xx <= r_q[1] * r_q[1];
            r_yy <= r_q[2] * r_q[2];
            r_wz <= r_q[0] * r_q[3];
            r_xy <= r_q[1] * r_q[2];
            r_zz <= r_q[3] * r_q[3];
            r_wy <= r_q[0] * r_q[2];
            r_zx <= r_q[3] * r_q[1];
        end
    end

    // Stage 3: doubled pair sums in Q30 (floor)
    assign w_sr = (P_W+1)'(r_wx) + (P_W+1)'(r_yz);
    assign w_cr = (P_W+1)'(r_xx) + (P_W+1)'(r_yy);
    assign w_sy = (P_W+1)'(r_wz) + (P_W+1)'(r_xy);
    assign w_cy = (P_W+1)'(r_yy) + (P_W+1)'(r_zz);
    assign w_sp = (P_W+1)'(r_wy) - (P_W+1)'(r_zx);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_terms.sinr <= w_sr[P_W:P_W-T_W+1];
            o_terms.cosr <= ONE_Q30 - w_cr[P_W:P_W-T_W+1];
            o_terms.siny <= w_sy[P_W:P_W-T_W+1];
            o_terms.cosy <= ONE_Q30 - w_cy[P_W:P_W-T_W+1];
            o_terms.sinp <= w_sp[P_W:P_W-T_W+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;

endmodule

/* design/qte_sqrt.sv */
module qte_sqrt import qte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_terms           i_terms,
    output logic             o_valid,
    output t_terms           o_terms,
    output logic [Q_W-1:0]   o_root,
    output logic             o_clamp
);

    logic signed [Q_W-1:0] w_s;
    logic                  w_clamp;
    logic [S_W-1:0]        r_sq;
    t_terms                r_t0;
    logic                  r_c0;
    logic                  r_v0;

    logic [S_W-1:0] r_n   [SQ_STEPS+1];
    logic [S_W-1:0] r_res [SQ_STEPS+1];
    t_terms         r_t   [SQ_STEPS+1];
    logic           r_c   [SQ_STEPS+1];
    logic           r_v   [SQ_STEPS+1];

    // Detect a pitch sine at or beyond one
    assign w_clamp = (i_terms.sinp >= ONE_Q30) || (i_terms.sinp <= -ONE_Q30);
    assign w_s     = i_terms.sinp[Q_W-1:0];

    // Square the sine
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sq <= S_W'(w_s * w_s);
            r_t0 <= i_terms;
            r_c0 <= w_clamp;
        end
    end

    // Form one minus the square
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_n[0]   <= (S_W'(1) << 60) - r_sq;
            r_res[0] <= '0;
            r_t[0]   <= r_t0;
            r_c[0]   <= r_c0;
        end
    end

    // One root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [S_W-1:0] BIT = S_W'(1) << (60 - 2 * k);
        logic [S_W-1:0] trial;
        assign trial = r_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (r_n[k] >= trial) begin
                    r_n[k+1]   <= r_n[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + BIT;
                end else begin
                    r_n[k+1]   <= r_n[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
                r_t[k+1] <= r_t[k];
                r_c[k+1] <= r_c[k];
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_v[k] <= 1'b0;
        end else if (i_adv) begin
            r_v0   <= i_valid;
            r_v[0] <= r_v0;
            for (int k = 1; k <= SQ_STEPS; k++) r_v[k] <= r_v[k-1];
        end
    end

    assign o_valid = r_v[SQ_STEPS];
    assign o_terms = r_t[SQ_STEPS];
    assign o_root  = r_res[SQ_STEPS][Q_W-1:0];
    assign o_clamp = r_c[SQ_STEPS];

endmodule

/* design/qte_cordic.sv */
module qte_cordic import qte_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic signed [C_W-1:0] i_y,
    input  logic signed [C_W-1:0] i_x,
    output logic                  o_valid,
    output logic signed [A_W-1:0] o_angle
);

    logic signed [C_W-1:0] r_x [STEPS+1];
    logic signed [C_W-1:0] r_y [STEPS+1];
    logic signed [A_W-1:0] r_z [STEPS+1];
    logic                  r_zero [STEPS+1];
    logic                  r_v [STEPS+1];
    logic                  r_ov;

    // Pre-rotate into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // Vectoring iterations
    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        localparam logic signed [A_W-1:0] ANG = A_W'(ATAN_TAB[i]);
        logic signed [C_W-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ANG;
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // Limit to a half turn; zero vector gives zero
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (r_zero[STEPS]) begin
                o_angle <= '0;
            end else if (r_z[STEPS] > PI_Q30) begin
                o_angle <= PI_Q30;
            end else if (r_z[STEPS] < -PI_Q30) begin
                o_angle <= -PI_Q30;
            end else begin
                o_angle <= r_z[STEPS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= STEPS; i++) r_v[i] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= STEPS; i++) r_v[i] <= r_v[i-1];
            r_ov <= r_v[STEPS];
        end
    end

    assign o_valid = r_ov;

endmodule

/* design/qte_encode.sv */
module qte_encode import qte_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic                  i_deg,
    input  logic signed [A_W-1:0] i_roll,
    input  logic signed [A_W-1:0] i_pitch,
    input  logic signed [A_W-1:0] i_yaw,
    input  logic                  i_clamp,
    input  logic                  i_sinp_pos,
    output logic                  o_valid,
    output logic signed [15:0]    o_roll,
    output logic signed [14:0]    o_pitch,
    output logic signed [15:0]    o_yaw,
    output logic                  o_clamped
);

    logic signed [A_W-1:0] w_a [3];
    logic signed [A_W-1:0] r_a [3];
    logic signed [48:0]    r_ph [3];
    logic signed [47:0]    r_pl [3];
    logic                  r_clamp;
    logic                  r_v;
    logic signed [63:0]    w_p [3];
    logic signed [A_W-1:0] w_s [3];

    // Select pitch: clamp by the sine, else limit to a quarter turn
    always_comb begin
        w_a[0] = i_roll;
        w_a[2] = i_yaw;
        if (i_clamp) begin
            w_a[1] = i_sinp_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
        end else if (i_pitch > HALF_PI_Q30) begin
            w_a[1] = HALF_PI_Q30;
        end else if (i_pitch < -HALF_PI_Q30) begin
            w_a[1] = -HALF_PI_Q30;
        end else begin
            w_a[1] = i_pitch;
        end
    end

    // Degree scaling as two partial products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k]  <= w_a[k];
                r_ph[k] <= $signed(w_a[k][A_W-1:16]) * RAD2DEG_Q24;
                r_pl[k] <= $signed({1'b0, w_a[k][15:0]}) * RAD2DEG_Q24;
            end
            r_clamp <= i_clamp;
        end
    end

    // Combine and round half up
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p[k] = (64'(r_ph[k]) <<< 16) + 64'(r_pl[k]) + (64'sd1 <<< 46);
            w_s[k] = r_a[k] + 34'sd65536;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_roll    <= i_deg ? w_p[0][62:47] : w_s[0][32:17];
            o_pitch   <= i_deg ? w_p[1][61:47] : w_s[1][31:17];
            o_yaw     <= i_deg ? w_p[2][62:47] : w_s[2][32:17];
            o_clamped <= r_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_v     <= i_valid;
            o_valid <= r_v;
        end
    end

endmodule

/* design/quaternion_to_euler_angles.sv */
// Pipeline stages: 3 product/sum stages, 33 square-root stages,
// CORDIC_STEPS + 2 CORDIC stages, 2 scaling stages.
// Throughput: one quaternion per cycle; the whole pipeline holds on output stall,
// and a one-entry input skid register keeps o_stall registered.
// Reset (synchronous, i_rst_n low): clears all valid bits, the skid and the mode
// register (radians).
`include "assert_macros.svh"

module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int CORDIC_STEPS    = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [15:0]                o_roll_angle,
    output logic signed [14:0]                o_pitch_angle,
    output logic signed [15:0]                o_yaw_angle,
    output logic                              o_pitch_clamped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data
);

    localparam int CORDIC_LAT = CORDIC_STEPS + 2;

    logic w_adv, w_accept;
    logic r_skid_valid;
    logic signed [COMPONENT_WIDTH-1:0] r_skid_w, r_skid_x, r_skid_y, r_skid_z;
    logic signed [COMPONENT_WIDTH-1:0] w_pw, w_px, w_py, w_pz;
    logic w_pvalid;
    logic r_deg;

    logic   w_front_valid;
    t_terms w_front_terms;
    logic   w_sq_valid;
    t_terms w_sq_terms;
    logic [Q_W-1:0] w_root;
    logic   w_sq_clamp;
    logic   w_cor_valid;
    logic signed [A_W-1:0] w_roll, w_pitch, w_yaw;
    logic [1:0] r_pf [CORDIC_LAT];

    // Advance the whole pipeline unless a finished result is held
    assign w_adv    = !(o_valid && i_stall);
    assign w_accept = i_valid && !r_skid_valid;
    assign o_stall  = r_skid_valid;

    // Park a request that arrives while the pipeline holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && w_accept) begin
            r_skid_w <= i_quat_w;
            r_skid_x <= i_quat_x;
            r_skid_y <= i_quat_y;
            r_skid_z <= i_quat_z;
        end
    end

    assign w_pvalid = r_skid_valid || w_accept;
    assign w_pw     = r_skid_valid ? r_skid_w : i_quat_w;
    assign w_px     = r_skid_valid ? r_skid_x : i_quat_x;
    assign w_py     = r_skid_valid ? r_skid_y : i_quat_y;
    assign w_pz     = r_skid_valid ? r_skid_z : i_quat_z;

    // Mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_deg <= i_cfg_data;
        end
    end

    qte_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_pvalid),
        .i_w     (w_pw),
        .i_x     (w_px),
        .i_y     (w_py),
        .i_z     (w_pz),
        .o_valid (w_front_valid),
        .o_terms (w_front_terms)
    );

    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_front_valid),
        .i_terms (w_front_terms),
        .o_valid (w_sq_valid),
        .o_terms (w_sq_terms),
        .o_root  (w_root),
        .o_clamp (w_sq_clamp)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sq_valid),
        .i_y     (C_W'(w_sq_terms.sinr)),
        .i_x     (C_W'(w_sq_terms.cosr)),
        .o_valid (w_cor_valid),
        .o_angle (w_roll)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sq_valid),
        .i_y     (C_W'(w_sq_terms.sinp)),
        .i_x     (C_W'({1'b0, w_root})),
        .o_valid (),
        .o_angle (w_pitch)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sq_valid),
        .i_y     (C_W'(w_sq_terms.siny)),
        .i_x     (C_W'(w_sq_terms.cosy)),
        .o_valid (),
        .o_angle (w_yaw)
    );

    // Delay the pitch clamp flag and sine sign alongside the CORDIC
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pf[0] <= {w_sq_clamp, (w_sq_terms.sinp > 0)};
            for (int k = 1; k < CORDIC_LAT; k++) r_pf[k] <= r_pf[k-1];
        end
    end

    qte_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (w_cor_valid),
        .i_deg      (r_deg),
        .i_roll     (w_roll),
        .i_pitch    (w_pitch),
        .i_yaw      (w_yaw),
        .i_clamp    (r_pf[CORDIC_LAT-1][1]),
        .i_sinp_pos (r_pf[CORDIC_LAT-1][0]),
        .o_valid    (o_valid),
        .o_roll     (o_roll_angle),
        .o_pitch    (o_pitch_angle),
        .o_yaw      (o_yaw_angle),
        .o_clamped  (o_pitch_clamped)
    );

    // Skid drains whenever the pipeline moves
    `QTE_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, w_adv, !r_skid_valid, "skid not drained")
    // A parked request stays valid, with w and z stable, while the pipeline is held
    `QTE_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !w_adv,
        r_skid_valid && $stable(r_skid_w) && $stable(r_skid_z), "parked request lost")
    // A clamped pitch in radians is a quarter turn
    `QTE_ASSERT_IMP(a_clamp_rad, i_clk, i_rst_n, o_valid && o_pitch_clamped && !r_deg,
        o_pitch_angle == 15'sd12868 || o_pitch_angle == -15'sd12868, "bad clamped pitch")

endmodule
